FILE: rtl/tlng_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and neighbour offset table for the triangular lattice gather.
package tlng_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int STATE_BITS = 8;

   localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS  = COL_BITS + ROW_BITS;

   // request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_SWAP  = 2'd2;

   // register indexes
   localparam logic [2:0] REG_MOORE  = 3'd0;
   localparam logic [2:0] REG_WRAP_H = 3'd1;
   localparam logic [2:0] REG_WRAP_V = 3'd2;
   localparam logic [2:0] REG_WIDTH  = 3'd3;
   localparam logic [2:0] REG_HEIGHT = 3'd4;

   localparam logic [3:0] MOORE_LAST_SLOT = 4'd12;
   localparam logic [3:0] EDGE_LAST_SLOT  = 4'd3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH
   } tlng_state_type;

   typedef struct packed {
      logic       moore;
      logic       wrap_h;
      logic       wrap_v;
      logic [6:0] width;
      logic [6:0] height;
   } tlng_cfg_type;

   typedef struct packed {
      logic                 clear;
      logic [ADDR_BITS-1:0] clear_addr;
      logic                 write;
      logic                 swap;
      logic                 start;
      logic                 issue;
      logic [3:0]           slot;
      logic                 last;
   } tlng_cmd_type;

   typedef struct packed {
      logic in_range;
      logic issue_ready;
   } tlng_sts_type;

   typedef struct packed {
      logic signed [2:0] dx;
      logic signed [1:0] dy;
   } tlng_offset_type;

   // Offset of a neighbour slot in row-major order for up/down cells.
   function automatic tlng_offset_type slot_offset(input logic moore, input logic up,
                                                   input logic [3:0] slot);
      tlng_offset_type   off;
      logic signed [4:0] s;
      s      = $signed({1'b0, slot});
      off.dx = 3'sd0;
      off.dy = 2'sd0;
      if (moore) begin
         if (up) begin
            if (slot inside {[4'd0:4'd2]}) begin
               off.dy = -2'sd1;
               off.dx = 3'(s - 5'sd1);
            end else if (slot inside {[4'd3:4'd7]}) begin
               off.dx = 3'(s - 5'sd5);
            end else begin
               off.dy = 2'sd1;
               off.dx = 3'(s - 5'sd10);
            end
         end else begin
            if (slot inside {[4'd0:4'd4]}) begin
               off.dy = -2'sd1;
               off.dx = 3'(s - 5'sd2);
            end else if (slot inside {[4'd5:4'd9]}) begin
               off.dx = 3'(s - 5'sd7);
            end else begin
               off.dy = 2'sd1;
               off.dx = 3'(s - 5'sd11);
            end
         end
      end else if (up) begin
         case (slot)
            4'd0: off.dx = -3'sd1;
            4'd1: off.dx = 3'sd0;
            4'd2: off.dx = 3'sd1;
            default: off.dy = 2'sd1;
         endcase
      end else begin
         case (slot)
            4'd0: off.dy = -2'sd1;
            4'd1: off.dx = -3'sd1;
            4'd2: off.dx = 3'sd0;
            default: off.dx = 3'sd1;
         endcase
      end
      return off;
   endfunction

endpackage

FILE: rtl/triangular_lattice_neighbor_gather.sv
`timescale 1ns / 1ps
// Top level of the triangular lattice neighbour gather: registers, controller and datapath.
//
// Usage
//  - Request channel (req_*): mode 0 writes write_value into the back buffer at
//    (column,row), mode 1 queries the neighbourhood of (column,row) in the front
//    buffer, mode 2 swaps the buffers. Mode 3, and writes or queries outside the
//    grid in use, are taken and dropped.
//  - Response channel (rsp_*): one response per neighbour, slot in row-major
//    order, last marks the final neighbour.
//  - Register port (csr_*): always ready; write only while the block is idle.
//  - After reset both cell buffers are zeroed by a sweep over all 4096 cells, one
//    cell per cycle in both memories; req_stall stays high meanwhile while
//    register writes are taken as usual.
//  - A query occupies the request side until every neighbour slot is issued (13
//    for Moore, 4 for edge-sharing): one memory read per neighbour from the
//    front buffer's single read port.
//  - A query's first response passes the coordinate, read and response registers,
//    then one per cycle while rsp_stall is low. A stalled receiver holds the
//    response register and read stage; the sequencer pauses until room frees up.
module triangular_lattice_neighbor_gather import tlng_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // requests
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [5:0] req_column,
   input  logic [5:0] req_row,
   input  logic [7:0] req_write_value,
   // responses
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_neighbor_state,
   output logic [3:0] rsp_neighbor_slot,
   output logic       rsp_last,
   // register writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [6:0] csr_wdata
);

   tlng_cfg_type cfg_ff;
   tlng_cmd_type cmd;
   tlng_sts_type sts;

   // register file, one write per cycle, never back-pressured
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.moore  <= 1'b1;
         cfg_ff.wrap_h <= 1'b0;
         cfg_ff.wrap_v <= 1'b0;
         cfg_ff.width  <= 7'd64;
         cfg_ff.height <= 7'd64;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MOORE:  cfg_ff.moore  <= csr_wdata[0];
            REG_WRAP_H: cfg_ff.wrap_h <= csr_wdata[0];
            REG_WRAP_V: cfg_ff.wrap_v <= csr_wdata[0];
            REG_WIDTH:  cfg_ff.width  <= csr_wdata;
            REG_HEIGHT: cfg_ff.height <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer: clearing sweep, decode, one neighbour slot per free read slot
   tlng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .moore     (cfg_ff.moore),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // cell buffers, address generation, read stage and response register
   tlng_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .cmd                (cmd),
      .req_column         (req_column),
      .req_row            (req_row),
      .req_write_value    (req_write_value),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_neighbor_state (rsp_neighbor_state),
      .rsp_neighbor_slot  (rsp_neighbor_slot),
      .rsp_last           (rsp_last)
   );

endmodule

FILE: rtl/tlng_ctrl.sv
`timescale 1ns / 1ps
// Controller: clearing sweep, request decode and neighbour slot sequencing.
module tlng_ctrl import tlng_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [1:0]   req_mode,
   input  logic         moore,
   input  tlng_sts_type sts,
   output logic         req_stall,
   output tlng_cmd_type cmd
);

   tlng_state_type       state_ff, state_in;
   logic [3:0]           slot_ff, slot_in;
   logic [ADDR_BITS-1:0] clear_cnt_ff, clear_cnt_in;
   logic [3:0]           last_slot;
   logic                 accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         slot_ff      <= '0;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   assign last_slot = moore ? MOORE_LAST_SLOT : EDGE_LAST_SLOT;
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      clear_cnt_in = clear_cnt_ff;
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.clear_addr = clear_cnt_ff;
      cmd.slot       = slot_ff;
      cmd.last       = (slot_ff == last_slot);
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear    = 1'b1;
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == ADDR_BITS'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            slot_in   = '0;
            if (accept) begin
               case (req_mode)
                  MODE_WRITE: cmd.write = sts.in_range;
                  MODE_SWAP:  cmd.swap  = 1'b1;
                  MODE_QUERY: begin
                     if (sts.in_range) begin
                        cmd.start = 1'b1;
                        state_in  = ST_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            if (sts.issue_ready) begin
               cmd.issue = 1'b1;
               slot_in   = slot_ff + 1'b1;
               if (slot_ff == last_slot) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/tlng_datapath.sv
`timescale 1ns / 1ps
// Datapath: double-buffered cell memories, neighbour addressing and result pipeline.
module tlng_datapath import tlng_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  tlng_cfg_type          cfg,
   input  tlng_cmd_type          cmd,
   input  logic [COL_BITS-1:0]   req_column,
   input  logic [ROW_BITS-1:0]   req_row,
   input  logic [7:0]            req_write_value,
   output tlng_sts_type          sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_neighbor_state,
   output logic [3:0]            rsp_neighbor_slot,
   output logic                  rsp_last
);

   logic [STATE_BITS-1:0] mem_a [CELL_COUNT];
   logic [STATE_BITS-1:0] mem_b [CELL_COUNT];
   logic [STATE_BITS-1:0] rd_a_ff, rd_b_ff;

   logic                  front_is_a_ff, front_is_a_in;
   logic [COL_BITS-1:0]   col_ff;
   logic [ROW_BITS-1:0]   row_ff;

   logic                  p1_valid_ff, p1_valid_in;
   logic                  p1_sel_a_ff;
   logic                  p1_zero_ff;
   logic [3:0]            p1_slot_ff;
   logic                  p1_last_ff;
   logic                  p1_advance;

   logic                  o_valid_ff, o_valid_in;
   logic [7:0]            o_state_ff;
   logic [3:0]            o_slot_ff;
   logic                  o_last_ff;

   logic [6:0]            w_use, h_use;
   logic                  up;
   tlng_offset_type       off;
   logic signed [8:0]     x_raw, y_raw;
   logic                  x_out, y_out;
   logic [COL_BITS-1:0]   x_wr;
   logic [ROW_BITS-1:0]   y_wr;
   logic [ADDR_BITS-1:0]  rd_addr, wr_addr;
   logic [STATE_BITS-1:0] wr_data;
   logic                  we_a, we_b;

   function automatic logic [6:0] clamp_size(input logic [6:0] v, input int unsigned max);
      logic [6:0] r;
      r = v;
      if (v == 7'd0) begin
         r = 7'd1;
      end else if (32'(v) > max) begin
         r = 7'(max);
      end
      return r;
   endfunction

   // true modulo for a coordinate at most two sizes beyond either edge
   function automatic logic [5:0] wrap_coord(input logic signed [8:0] v,
                                             input logic [6:0] size);
      logic signed [8:0] s;
      logic signed [8:0] t;
      s = $signed({2'b00, size});
      t = v;
      if (t < 0) t = t + s;
      else if (t >= s) t = t - s;
      if (t < 0) t = t + s;
      else if (t >= s) t = t - s;
      return t[5:0];
   endfunction

   assign w_use = clamp_size(cfg.width, MAX_WIDTH);
   assign h_use = clamp_size(cfg.height, MAX_HEIGHT);

   assign sts.in_range = ({1'b0, req_column} < w_use) && ({1'b0, req_row} < h_use);

   // neighbour coordinates of the current slot
   assign up    = ~(col_ff[0] ^ row_ff[0]);
   assign off   = slot_offset(cfg.moore, up, cmd.slot);
   assign x_raw = $signed({3'b000, col_ff}) + 9'(off.dx);
   assign y_raw = $signed({3'b000, row_ff}) + 9'(off.dy);
   assign x_out = (x_raw < 0) || (x_raw >= $signed({2'b00, w_use}));
   assign y_out = (y_raw < 0) || (y_raw >= $signed({2'b00, h_use}));
   assign x_wr  = COL_BITS'(wrap_coord(x_raw, w_use));
   assign y_wr  = ROW_BITS'(wrap_coord(y_raw, h_use));
   assign rd_addr = {y_wr, x_wr};

   // write port: zero sweep or request into the back buffer
   assign wr_addr = cmd.clear ? cmd.clear_addr : {req_row, req_column};
   assign wr_data = cmd.clear ? '0 : STATE_BITS'(req_write_value);
   assign we_a    = cmd.clear || (cmd.write && !front_is_a_ff);
   assign we_b    = cmd.clear || (cmd.write && front_is_a_ff);

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (cmd.issue) begin
         rd_a_ff <= mem_a[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      if (cmd.issue) begin
         rd_b_ff <= mem_b[rd_addr];
      end
   end

   assign front_is_a_in = cmd.swap ? ~front_is_a_ff : front_is_a_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         col_ff <= req_column;
         row_ff <= req_row;
      end
      if (cmd.issue) begin
         p1_sel_a_ff <= front_is_a_ff;
         p1_zero_ff  <= (x_out && !cfg.wrap_h) || (y_out && !cfg.wrap_v);
         p1_slot_ff  <= cmd.slot;
         p1_last_ff  <= cmd.last;
      end
      if (p1_advance) begin
         o_state_ff <= p1_zero_ff ? 8'd0 : 8'(p1_sel_a_ff ? rd_a_ff : rd_b_ff);
         o_slot_ff  <= p1_slot_ff;
         o_last_ff  <= p1_last_ff;
      end
   end

   assign p1_advance      = p1_valid_ff && (!o_valid_ff || !rsp_stall);
   assign sts.issue_ready = !p1_valid_ff || p1_advance;
   assign p1_valid_in     = cmd.issue || (p1_valid_ff && !p1_advance);
   assign o_valid_in      = p1_advance || (o_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_is_a_ff <= 1'b1;
         p1_valid_ff   <= 1'b0;
         o_valid_ff    <= 1'b0;
      end else begin
         front_is_a_ff <= front_is_a_in;
         p1_valid_ff   <= p1_valid_in;
         o_valid_ff    <= o_valid_in;
      end
   end

   assign rsp_valid          = o_valid_ff;
   assign rsp_neighbor_state = o_state_ff;
   assign rsp_neighbor_slot  = o_slot_ff;
   assign rsp_last           = o_last_ff;

   a_issue_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (!p1_valid_ff || p1_advance))
      else $error("read issued while the read stage is blocked");

   a_clear_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !(cmd.write || cmd.issue || cmd.swap || cmd.start))
      else $error("memory access during clearing sweep");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |->
         (rsp_neighbor_slot == MOORE_LAST_SLOT || rsp_neighbor_slot == EDGE_LAST_SLOT))
      else $error("final neighbour carries a wrong slot");

   a_p1_holds: assert property (@(posedge clock) disable iff (reset)
      (p1_valid_ff && !p1_advance) |=> p1_valid_ff)
      else $error("blocked read stage lost its data");

endmodule
